/* src/bc3_pkg.sv */
// Package for the BC3 block decoder: field widths, stream packing and palette arithmetic.
package bc3_pkg;

  localparam int unsigned HalfW     = 64;
  localparam int unsigned DimW      = 3;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned PixW      = 2;
  localparam int unsigned PixCnt    = 16;
  localparam int unsigned PosW      = 4;
  localparam int unsigned AIdxW     = 3;
  localparam int unsigned CIdxW     = 2;
  localparam int unsigned InFieldsW = 2 * HalfW + 2 * DimW;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = 2 * PixW + 4 * ChanW;
  localparam int unsigned OutDataW  = ((OutFieldsW + 7) / 8) * 8;

  localparam logic [15:0] Blue565Mask  = 16'h001F;
  localparam logic [15:0] Green565Mask = 16'h07E0;
  localparam logic [15:0] Red565Mask   = 16'hF800;
  localparam logic [5:0]  Green6Max    = 6'h3F;

  localparam logic [DimW-1:0] MaxDim = 3'd4;

  localparam logic [AIdxW-1:0] AlphaZeroIdx = 3'd6;
  localparam logic [AIdxW-1:0] AlphaFullIdx = 3'd7;
  localparam logic [ChanW-1:0] AlphaFull    = 8'hFF;

  localparam logic [CIdxW-1:0] CEnd0  = 2'd0;
  localparam logic [CIdxW-1:0] CEnd1  = 2'd1;
  localparam logic [CIdxW-1:0] CThird = 2'd2;
  localparam logic [CIdxW-1:0] CTwoThird = 2'd3;

  // floor(v*255/31) through a reciprocal of 2^18/31, rounded up
  function automatic logic [ChanW-1:0] expand5(input logic [4:0] v);
    logic [26:0] prod;
    prod = (27'(v) * 27'd255) * 27'd8457;
    return prod[25:18];
  endfunction

  // floor(v*255/63) through a reciprocal of 2^20/63, rounded up
  function automatic logic [ChanW-1:0] expand6(input logic [5:0] v);
    logic [28:0] prod;
    prod = (29'(v) * 29'd255) * 29'd16645;
    return prod[27:20];
  endfunction

  function automatic logic [ChanW-1:0] div7(input logic [10:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'd4682;
    return prod[22:15];
  endfunction

  function automatic logic [ChanW-1:0] div5(input logic [10:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'd6554;
    return prod[22:15];
  endfunction

  function automatic logic [ChanW-1:0] div3(input logic [9:0] x);
    logic [23:0] prod;
    prod = 24'(x) * 24'd10923;
    return prod[22:15];
  endfunction

  function automatic logic [ChanW-1:0] alpha_entry(input logic [ChanW-1:0] a0,
                                                   input logic [ChanW-1:0] a1,
                                                   input logic [AIdxW-1:0] ai);
    logic [ChanW-1:0] res;
    logic [AIdxW-1:0] wa;
    logic [AIdxW-1:0] wb;
    logic [10:0]      sum;
    wb  = ai - 3'd1;
    wa  = (a0 > a1) ? (3'd0 - ai) : (3'd6 - ai);
    sum = 11'(wa) * 11'(a0) + 11'(wb) * 11'(a1);
    if (ai == 3'd0) begin
      res = a0;
    end else if (ai == 3'd1) begin
      res = a1;
    end else if (a0 > a1) begin
      res = div7(sum);
    end else if (ai == AlphaZeroIdx) begin
      res = '0;
    end else if (ai == AlphaFullIdx) begin
      res = AlphaFull;
    end else begin
      res = div5(sum);
    end
    return res;
  endfunction

  function automatic logic [ChanW-1:0] color_entry(input logic [ChanW-1:0] c0,
                                                   input logic [ChanW-1:0] c1,
                                                   input logic [CIdxW-1:0] ci);
    logic [ChanW-1:0] res;
    unique case (ci)
      CEnd0:     res = c0;
      CEnd1:     res = c1;
      CThird:    res = div3({c0, 1'b0} + 10'(c1));
      CTwoThird: res = div3(10'(c0) + {c1, 1'b0});
      default:   res = c0;
    endcase
    return res;
  endfunction

endpackage

/* src/bc3_block_decoder.sv */
// BC3 block decoder: one 16-byte block in, its visible RGBA8 pixels out in row-major order.
// The first pixel of an accepted block goes from the block register to the output register.
// Throughput: one pixel per cycle unless the output stalls; a block of w x h visible pixels
// holds the input register until its last pixel leaves, when the next block is taken.
// A block with zero width or height is accepted and yields no pixel.
// Reset (synchronous, active high) empties the block and output registers.
module bc3_block_decoder
  import bc3_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // alpha_half[63:0], color_half[127:64], visible_width[130:128], visible_height[133:131]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // pixel_row[1:0], pixel_col[3:2], red[11:4], green[19:12], blue[27:20], alpha[35:28]
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  logic [HalfW-1:0] in_alpha_half;
  logic [HalfW-1:0] in_color_half;
  logic [DimW-1:0]  in_w;
  logic [DimW-1:0]  in_h;
  logic [DimW-1:0]  w_sat;
  logic [DimW-1:0]  h_sat;
  logic [15:0]      in_col0;
  logic [15:0]      in_col1;
  logic             in_accept;

  logic                          blk_valid;
  logic [ChanW-1:0]              blk_a0;
  logic [ChanW-1:0]              blk_a1;
  logic [PixCnt-1:0][AIdxW-1:0]  blk_aidx;
  logic [PixCnt-1:0][CIdxW-1:0]  blk_cidx;
  logic [ChanW-1:0]              blk_r0;
  logic [ChanW-1:0]              blk_r1;
  logic [ChanW-1:0]              blk_g0;
  logic [ChanW-1:0]              blk_g1;
  logic [ChanW-1:0]              blk_b0;
  logic [ChanW-1:0]              blk_b1;
  logic [DimW-1:0]               blk_w;
  logic [DimW-1:0]               blk_h;
  logic [PixW-1:0]               row;
  logic [PixW-1:0]               col;

  logic             out_free;
  logic             emit;
  logic             pix_last;
  logic             col_end;
  logic [PosW-1:0]  pos;
  logic [AIdxW-1:0] ai;
  logic [CIdxW-1:0] ci;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;
  logic [ChanW-1:0] alpha;

  assign in_alpha_half = s_axis_tdata[HalfW-1:0];
  assign in_color_half = s_axis_tdata[2*HalfW-1:HalfW];
  assign in_w          = s_axis_tdata[2*HalfW+DimW-1:2*HalfW];
  assign in_h          = s_axis_tdata[2*HalfW+2*DimW-1:2*HalfW+DimW];
  assign w_sat         = (in_w > MaxDim) ? MaxDim : in_w;
  assign h_sat         = (in_h > MaxDim) ? MaxDim : in_h;
  assign in_col0       = in_color_half[15:0];
  assign in_col1       = in_color_half[31:16];

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign emit      = blk_valid && out_free;
  assign col_end   = ({1'b0, col} == blk_w - 3'd1);
  assign pix_last  = col_end && ({1'b0, row} == blk_h - 3'd1);
  assign s_axis_tready = !blk_valid || (emit && pix_last);
  assign in_accept = s_axis_tvalid && s_axis_tready;

  assign pos   = {row, col};
  assign ai    = blk_aidx[pos];
  assign ci    = blk_cidx[pos];
  assign red   = color_entry(blk_r0, blk_r1, ci);
  assign green = color_entry(blk_g0, blk_g1, ci);
  assign blue  = color_entry(blk_b0, blk_b1, ci);
  assign alpha = alpha_entry(blk_a0, blk_a1, ai);

  always_ff @(posedge clk) begin
    if (rst) begin
      blk_valid <= 1'b0;
      row       <= '0;
      col       <= '0;
    end else if (in_accept) begin
      blk_valid <= (w_sat != '0) && (h_sat != '0);
      row       <= '0;
      col       <= '0;
    end else if (emit) begin
      if (pix_last) begin
        blk_valid <= 1'b0;
      end
      col <= col_end ? '0 : col + 2'd1;
      row <= col_end ? row + 2'd1 : row;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      blk_a0   <= in_alpha_half[7:0];
      blk_a1   <= in_alpha_half[15:8];
      blk_aidx <= in_alpha_half[HalfW-1:16];
      blk_cidx <= in_color_half[HalfW-1:32];
      blk_r0   <= expand5(5'((in_col0 & Red565Mask) >> 11));
      blk_r1   <= expand5(5'((in_col1 & Red565Mask) >> 11));
      blk_g0   <= expand6(Green6Max & 6'((in_col0 & Green565Mask) >> 5));
      blk_g1   <= expand6(Green6Max & 6'((in_col1 & Green565Mask) >> 5));
      blk_b0   <= expand5(5'(in_col0 & Blue565Mask));
      blk_b1   <= expand5(5'(in_col1 & Blue565Mask));
      blk_w    <= w_sat;
      blk_h    <= h_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {{(OutDataW-OutFieldsW){1'b0}}, alpha, blue, green, red, col, row};
      m_axis_tlast <= pix_last;
    end
  end

  a_accept_only_when_free: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (!blk_valid || (emit && pix_last)))
    else $error("block taken while pixels of the previous block remain");

  a_start_at_origin: assert property (@(posedge clk) disable iff (rst)
    (in_accept && w_sat != '0 && h_sat != '0) |=> (blk_valid && row == '0 && col == '0))
    else $error("new block does not start at the first pixel");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    blk_valid |-> (({1'b0, row} < blk_h) && ({1'b0, col} < blk_w)))
    else $error("pixel position outside the visible area");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (emit && pix_last && !s_axis_tvalid) |=> !blk_valid)
    else $error("block register still full after its last pixel");

  a_last_flagged: assert property (@(posedge clk) disable iff (rst)
    (emit && pix_last) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("last pixel of a block not flagged");

endmodule
